### rtl/core/spa_pkg.sv
// ----------------------------------------------------------------------------
// Sparse polynomial adder - shared types and constants
// Field widths, operation codes, command and result records used by the
// intake, the merge engine and the channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package spa_pkg;

	// Fixed field widths of the channels
	localparam int OP_BITS   = 2;
	localparam int COEF_BITS = 16;
	localparam int EXP_BITS  = 10;
	localparam int SUM_BITS  = COEF_BITS + 1;

	// Command queue between intake and merge engine
	localparam int QUEUE_DEPTH = 2;

	// Operation codes on the input channel
	localparam logic [OP_BITS-1:0] OP_LOAD_A = 2'd0;
	localparam logic [OP_BITS-1:0] OP_LOAD_B = 2'd1;
	localparam logic [OP_BITS-1:0] OP_RUN    = 2'd2;
	localparam logic [OP_BITS-1:0] OP_NONE   = 2'd3;

	typedef enum logic [1:0] {
		KIND_LOAD_A,
		KIND_LOAD_B,
		KIND_RUN
	} cmd_kind_t;

	// One stored term
	typedef struct packed {
		logic [COEF_BITS-1:0] coef;
		logic [EXP_BITS-1:0]  expo;
	} term_t;

	// One queued command
	typedef struct packed {
		cmd_kind_t kind;
		term_t     term;
	} cmd_t;

	// One result item
	typedef struct packed {
		logic [SUM_BITS-1:0] sum_coefficient;
		logic [EXP_BITS-1:0] sum_exponent;
		logic                empty_result;
		logic                last_term;
	} res_t;

endpackage

`default_nettype wire

### rtl/core/spa_intf.sv
// ----------------------------------------------------------------------------
// Sparse polynomial adder - channel interfaces
// Valid/ready channels for input items and for result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface spa_term_if;
	logic                               valid;
	logic                               ready;
	logic [spa_pkg::OP_BITS-1:0]        operation;
	logic signed [spa_pkg::COEF_BITS-1:0] coefficient;
	logic [spa_pkg::EXP_BITS-1:0]       exponent;

	modport source (output valid, output operation, output coefficient,
		output exponent, input ready);
	modport sink (input valid, input operation, input coefficient,
		input exponent, output ready);
endinterface

interface spa_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [spa_pkg::SUM_BITS-1:0] sum_coefficient;
	logic [spa_pkg::EXP_BITS-1:0]        sum_exponent;
	logic                                empty_result;
	logic                                last_term;

	modport source (output valid, output sum_coefficient, output sum_exponent,
		output empty_result, output last_term, input ready);
	modport sink (input valid, input sum_coefficient, input sum_exponent,
		input empty_result, input last_term, output ready);
endinterface

`default_nettype wire

### rtl/core/sparse_polynomial_add_core.sv
// ----------------------------------------------------------------------------
// Sparse polynomial adder - top level
// Intake with a two-entry command queue feeding the store-and-merge engine.
// ----------------------------------------------------------------------------
// Load items (operation 0 into store A, 1 into store B) write one term each
// and are taken at one per cycle while the command queue has room; a load
// into a full store is dropped, and operation 3 is taken and ignored. A run
// (operation 2) merges both stores in decreasing exponent order: it enters the
// merge state, then each merge step consumes the head term of A, of B or of
// both, a closing step ends the run, and no step is taken while the result
// sink stalls. Equal exponents are summed into a 17-bit coefficient and zero
// sums are dropped; the final result carries last_term, and a run with no
// surviving term gives one item with empty_result and last_term set. Both
// stores are empty after a run. The merge walk is set by the one registered
// read port of each store; the two-entry command queue takes up to two
// further items while a run drains and then holds the input off. Terms are
// expected in strictly decreasing exponent order per store.
`default_nettype none

module sparse_polynomial_add_core #(
	parameter int MAX_TERMS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	spa_term_if.sink    term,
	spa_result_if.source result
);
	import spa_pkg::*;

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;
	res_t res;

	spa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.term      (term),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	spa_back #(
		.MAX_TERMS (MAX_TERMS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_valid (result.valid),
		.res_ready (result.ready),
		.res       (res)
	);

	// Drive the result channel payload
	assign result.sum_coefficient = res.sum_coefficient;
	assign result.sum_exponent    = res.sum_exponent;
	assign result.empty_result    = res.empty_result;
	assign result.last_term       = res.last_term;

endmodule

`default_nettype wire

### rtl/core/spa_front.sv
// ----------------------------------------------------------------------------
// Sparse polynomial adder - intake
// Accepts input items, decodes the operation, drops unknown codes and
// queues load and run commands for the merge engine.
// ----------------------------------------------------------------------------
`default_nettype none

module spa_front (
	input  logic          clk,
	input  logic          arst_n,
	spa_term_if.sink      term,
	output logic          cmd_valid,
	output spa_pkg::cmd_t cmd,
	input  logic          cmd_pop
);
	import spa_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             queue_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             full;
	logic             take;
	logic             keep;
	logic             push;
	cmd_t             cmd_new;

	// Accept whenever the queue has room
	assign full       = (fill_q == CNT_W'(QUEUE_DEPTH));
	assign term.ready = !full;
	assign take       = term.valid && term.ready;

	// Classify the operation
	always_comb begin
		cmd_new.term.coef = term.coefficient;
		cmd_new.term.expo = term.exponent;
		cmd_new.kind      = KIND_RUN;
		keep              = 1'b1;
		unique case (term.operation)
			OP_LOAD_A: cmd_new.kind = KIND_LOAD_A;
			OP_LOAD_B: cmd_new.kind = KIND_LOAD_B;
			OP_RUN:    cmd_new.kind = KIND_RUN;
			OP_NONE:   keep = 1'b0;
			default:   keep = 1'b0;
		endcase
	end

	assign push = take && keep;

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cmd_new;
		end
	end

	// Queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !cmd_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (!push && cmd_pop) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	assign cmd_valid = (fill_q != '0);
	assign cmd       = queue_q[rd_ptr_q];

endmodule

`default_nettype wire

### rtl/core/spa_back.sv
// ----------------------------------------------------------------------------
// Sparse polynomial adder - merge engine
// Holds the two term stores, executes loads and walks both stores in one
// merge pass on a run, with a one-term holding register that lets the final
// result carry its last mark and an output register towards the sink.
// ----------------------------------------------------------------------------
`default_nettype none

module spa_back #(
	parameter int MAX_TERMS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  spa_pkg::cmd_t cmd,
	output logic          cmd_pop,
	output logic          res_valid,
	input  logic          res_ready,
	output spa_pkg::res_t res
);
	import spa_pkg::*;

	localparam int IDX_W = $clog2(MAX_TERMS);
	localparam int CNT_W = $clog2(MAX_TERMS + 1);
	localparam int EXT_W = SUM_BITS - COEF_BITS;

	typedef enum logic {
		ST_IDLE,
		ST_MERGE
	} state_t;

	state_t              state_q;
	term_t               a_mem [MAX_TERMS];
	term_t               b_mem [MAX_TERMS];
	term_t               a_rd_q;
	term_t               b_rd_q;
	logic [CNT_W-1:0]    a_cnt_q;
	logic [CNT_W-1:0]    b_cnt_q;
	logic [CNT_W-1:0]    i_q;
	logic [CNT_W-1:0]    j_q;
	logic                pend_valid_q;
	logic [SUM_BITS-1:0] pend_coef_q;
	logic [EXP_BITS-1:0] pend_expo_q;
	logic                res_valid_q;
	res_t                res_q;

	logic                a_full;
	logic                b_full;
	logic                a_we;
	logic                b_we;
	logic                a_live;
	logic                b_live;
	logic                done;
	logic                can_push;
	logic                step;
	logic                res_load;
	logic                take_a;
	logic                take_b;
	logic                new_keep;
	logic [SUM_BITS-1:0] a_sx;
	logic [SUM_BITS-1:0] b_sx;
	logic [SUM_BITS-1:0] ab_sum;
	logic [SUM_BITS-1:0] new_coef;
	logic [EXP_BITS-1:0] new_expo;
	logic [CNT_W-1:0]    i_nxt;
	logic [CNT_W-1:0]    j_nxt;
	logic [IDX_W-1:0]    a_addr;
	logic [IDX_W-1:0]    b_addr;

	// Store writes from load commands
	assign a_full  = (a_cnt_q == CNT_W'(MAX_TERMS));
	assign b_full  = (b_cnt_q == CNT_W'(MAX_TERMS));
	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;
	assign a_we    = cmd_pop && (cmd.kind == KIND_LOAD_A) && !a_full;
	assign b_we    = cmd_pop && (cmd.kind == KIND_LOAD_B) && !b_full;

	// Compare the two head terms and pick the next result term
	assign a_live = (i_q < a_cnt_q);
	assign b_live = (j_q < b_cnt_q);
	assign done   = !a_live && !b_live;
	assign a_sx   = {{EXT_W{a_rd_q.coef[COEF_BITS-1]}}, a_rd_q.coef};
	assign b_sx   = {{EXT_W{b_rd_q.coef[COEF_BITS-1]}}, b_rd_q.coef};
	assign ab_sum = a_sx + b_sx;

	always_comb begin
		take_a   = 1'b0;
		take_b   = 1'b0;
		new_coef = a_sx;
		new_expo = a_rd_q.expo;
		priority if (a_live && b_live) begin
			priority if (a_rd_q.expo < b_rd_q.expo) begin
				take_b   = 1'b1;
				new_coef = b_sx;
				new_expo = b_rd_q.expo;
			end else if (a_rd_q.expo == b_rd_q.expo) begin
				take_a   = 1'b1;
				take_b   = 1'b1;
				new_coef = ab_sum;
			end else begin
				take_a = 1'b1;
			end
		end else if (a_live) begin
			take_a = 1'b1;
		end else if (b_live) begin
			take_b   = 1'b1;
			new_coef = b_sx;
			new_expo = b_rd_q.expo;
		end else begin
			take_a = 1'b0;
		end
	end

	// Drop cancelled sums
	assign new_keep = (take_a && take_b) ? (ab_sum != '0) : (take_a || take_b);

	// Advance only when the output register can take a term
	assign can_push = !res_valid_q || res_ready;
	assign step     = (state_q == ST_MERGE) && can_push;
	assign res_load = step && (done || (new_keep && pend_valid_q));
	assign i_nxt    = i_q + CNT_W'(take_a);
	assign j_nxt    = j_q + CNT_W'(take_b);
	assign a_addr   = (step ? i_nxt[IDX_W-1:0] : i_q[IDX_W-1:0]);
	assign b_addr   = (step ? j_nxt[IDX_W-1:0] : j_q[IDX_W-1:0]);

	// Term stores: one write and one registered read each
	always_ff @(posedge clk) begin
		if (a_we) begin
			a_mem[a_cnt_q[IDX_W-1:0]] <= cmd.term;
		end
		a_rd_q <= a_mem[a_addr];
	end

	always_ff @(posedge clk) begin
		if (b_we) begin
			b_mem[b_cnt_q[IDX_W-1:0]] <= cmd.term;
		end
		b_rd_q <= b_mem[b_addr];
	end

	// Sequencer, holding register and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			a_cnt_q      <= '0;
			b_cnt_q      <= '0;
			i_q          <= '0;
			j_q          <= '0;
			pend_valid_q <= 1'b0;
			pend_coef_q  <= '0;
			pend_expo_q  <= '0;
			res_valid_q  <= 1'b0;
			res_q        <= '0;
		end else begin
			// Offer a new result, or release the output register on transfer
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (a_we) begin
						a_cnt_q <= a_cnt_q + 1'b1;
					end
					if (b_we) begin
						b_cnt_q <= b_cnt_q + 1'b1;
					end
					if (cmd_pop && (cmd.kind == KIND_RUN)) begin
						state_q <= ST_MERGE;
					end
				end
				ST_MERGE: begin
					if (step) begin
						if (done) begin
							// Close the run with the held term or an empty marker
							res_q.sum_coefficient <= pend_valid_q ? pend_coef_q : '0;
							res_q.sum_exponent    <= pend_valid_q ? pend_expo_q : '0;
							res_q.empty_result    <= !pend_valid_q;
							res_q.last_term       <= 1'b1;
							pend_valid_q          <= 1'b0;
							a_cnt_q               <= '0;
							b_cnt_q               <= '0;
							i_q                   <= '0;
							j_q                   <= '0;
							state_q               <= ST_IDLE;
						end else begin
							i_q <= i_nxt;
							j_q <= j_nxt;
							if (new_keep) begin
								// Pass the held term on and hold the new one
								if (pend_valid_q) begin
									res_q.sum_coefficient <= pend_coef_q;
									res_q.sum_exponent    <= pend_expo_q;
									res_q.empty_result    <= 1'b0;
									res_q.last_term       <= 1'b0;
								end
								pend_valid_q <= 1'b1;
								pend_coef_q  <= new_coef;
								pend_expo_q  <= new_expo;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

### rtl/core/spa_checker.sv
// ----------------------------------------------------------------------------
// Sparse polynomial adder - port checker
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module spa_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic [spa_pkg::SUM_BITS-1:0] sum_coefficient,
	input logic [spa_pkg::EXP_BITS-1:0] sum_exponent,
	input logic                         empty_result,
	input logic                         last_term
);
	import spa_pkg::*;

	localparam logic [SUM_BITS-1:0] SUM_UNREACHABLE = {1'b0, {(SUM_BITS - 1){1'b1}}};

	// A stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result valid dropped while stalled");

	// A stalled result keeps its payload
	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(sum_coefficient) && $stable(sum_exponent)
			&& $stable(empty_result) && $stable(last_term))
		else $error("result payload changed while stalled");

	// An empty sum closes the run and carries zero fields
	a_empty_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && empty_result |-> last_term && (sum_coefficient == '0)
			&& (sum_exponent == '0))
		else $error("empty result malformed");

	// The sum of two coefficients never reaches the top positive code
	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !empty_result |-> sum_coefficient != SUM_UNREACHABLE)
		else $error("result coefficient out of range");

endmodule

bind sparse_polynomial_add_core spa_checker u_spa_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.res_valid       (result.valid),
	.res_ready       (result.ready),
	.sum_coefficient (result.sum_coefficient),
	.sum_exponent    (result.sum_exponent),
	.empty_result    (result.empty_result),
	.last_term       (result.last_term)
);

`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// Sparse polynomial adder - self-checking testbench
// Loads term stores A and B over the term channel, triggers merges and checks
// every result term against a local merge predictor. A queue-fed driver and
// a clocked monitor run through phases of sender gaps and sink back-pressure.
// ----------------------------------------------------------------------------
module tb;
	import spa_pkg::*;

	localparam int TERMS    = 32;
	localparam int ITEMS    = 330;
	localparam int WATCHDOG = 4000;
	localparam int TAIL     = 100;

	typedef struct {
		logic [OP_BITS-1:0]          op;
		logic signed [COEF_BITS-1:0] coef;
		logic [EXP_BITS-1:0]         expo;
	} term_item_t;

	logic clk;
	logic arst_n;

	spa_term_if   term_ch ();
	spa_result_if result_ch ();

	sparse_polynomial_add_core #(
		.MAX_TERMS(TERMS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.term   (term_ch),
		.result (result_ch)
	);

	term_item_t pending[$];
	res_t       due_terms[$];

	// Predictor copy of both term stores
	logic signed [COEF_BITS-1:0] held_a_coef[TERMS];
	logic [EXP_BITS-1:0]         held_a_expo[TERMS];
	logic signed [COEF_BITS-1:0] held_b_coef[TERMS];
	logic [EXP_BITS-1:0]         held_b_expo[TERMS];
	int held_a_n;
	int held_b_n;

	int errors;
	int quiet;
	int sent_n;
	int stim_n;
	int total_n;

	always #6 clk = ~clk;

	// Current idling phase, by share of items already transferred
	function automatic int phase_of();
		int p;
		if (total_n == 0)
			return 0;
		p = (sent_n * 4) / total_n;
		return (p > 3) ? 3 : p;
	endfunction

	function automatic int send_idle_pct(input int p);
		case (p)
			1: return 51;
			3: return 33;
			default: return 0;
		endcase
	endfunction

	function automatic int sink_stall_pct(input int p);
		case (p)
			2: return 51;
			3: return 33;
			default: return 0;
		endcase
	endfunction

	function automatic logic signed [COEF_BITS-1:0] rand_coef();
		case ($urandom_range(0, 7))
			0: rand_coef = {1'b1, {(COEF_BITS-1){1'b0}}};
			1: rand_coef = {1'b0, {(COEF_BITS-1){1'b1}}};
			2: rand_coef = COEF_BITS'($urandom_range(0, 8) - 4);
			default: rand_coef = COEF_BITS'($urandom);
		endcase
	endfunction

	function automatic res_t make_term(input logic [SUM_BITS-1:0] coef,
		input logic [EXP_BITS-1:0] expo);
		res_t r;
		r.sum_coefficient = coef;
		r.sum_exponent    = expo;
		r.empty_result    = 1'b0;
		r.last_term       = 1'b0;
		return r;
	endfunction

	// Merge both stores into due terms, then empty them
	task automatic merge_stores();
		int i;
		int j;
		int n;
		logic [SUM_BITS-1:0] s;
		res_t r;
		i = 0;
		j = 0;
		n = 0;
		while (i < held_a_n && j < held_b_n) begin
			if (held_a_expo[i] < held_b_expo[j]) begin
				due_terms.push_back(make_term({held_b_coef[j][COEF_BITS-1], held_b_coef[j]},
					held_b_expo[j]));
				n++;
				j++;
			end else if (held_a_expo[i] == held_b_expo[j]) begin
				s = {held_a_coef[i][COEF_BITS-1], held_a_coef[i]} +
					{held_b_coef[j][COEF_BITS-1], held_b_coef[j]};
				if (s != '0) begin
					due_terms.push_back(make_term(s, held_a_expo[i]));
					n++;
				end
				i++;
				j++;
			end else begin
				due_terms.push_back(make_term({held_a_coef[i][COEF_BITS-1], held_a_coef[i]},
					held_a_expo[i]));
				n++;
				i++;
			end
		end
		for (; i < held_a_n; i++) begin
			due_terms.push_back(make_term({held_a_coef[i][COEF_BITS-1], held_a_coef[i]},
				held_a_expo[i]));
			n++;
		end
		for (; j < held_b_n; j++) begin
			due_terms.push_back(make_term({held_b_coef[j][COEF_BITS-1], held_b_coef[j]},
				held_b_expo[j]));
			n++;
		end
		held_a_n = 0;
		held_b_n = 0;
		// Mark the final term, or give the empty-sum item when nothing survived
		if (n == 0) begin
			r = make_term('0, '0);
			r.empty_result = 1'b1;
			r.last_term    = 1'b1;
			due_terms.push_back(r);
		end else begin
			r = due_terms.pop_back();
			r.last_term = 1'b1;
			due_terms.push_back(r);
		end
	endtask

	task automatic apply_item(input logic [OP_BITS-1:0] op,
		input logic signed [COEF_BITS-1:0] coef, input logic [EXP_BITS-1:0] expo);
		case (op)
			OP_LOAD_A: begin
				if (held_a_n < TERMS) begin
					held_a_coef[held_a_n] = coef;
					held_a_expo[held_a_n] = expo;
					held_a_n++;
				end
			end
			OP_LOAD_B: begin
				if (held_b_n < TERMS) begin
					held_b_coef[held_b_n] = coef;
					held_b_expo[held_b_n] = expo;
					held_b_n++;
				end
			end
			OP_RUN: begin
				merge_stores();
			end
			default: begin
			end
		endcase
	endtask

	task automatic push_item(input logic [OP_BITS-1:0] op,
		input logic signed [COEF_BITS-1:0] coef, input logic [EXP_BITS-1:0] expo);
		term_item_t it;
		it.op   = op;
		it.coef = coef;
		it.expo = expo;
		pending.push_back(it);
		if (op != OP_NONE)
			stim_n++;
	endtask

	// Queue one sorted pair of term lists with shared exponents, then a run
	task automatic queue_merge_case(input int k);
		bit used[1024];
		logic signed [COEF_BITS-1:0] ac[$];
		logic signed [COEF_BITS-1:0] bc[$];
		logic [EXP_BITS-1:0] ae[$];
		logic [EXP_BITS-1:0] be[$];
		logic signed [COEF_BITS-1:0] c;
		int picked;
		int e;
		int ia;
		int ib;
		int role;
		bit take_a;
		picked = 0;
		while (picked < k) begin
			e = $urandom_range(0, 1023);
			if (!used[e]) begin
				used[e] = 1'b1;
				picked++;
			end
		end
		// Walk downwards so that both lists come out strictly decreasing
		for (e = 1023; e >= 0; e--) begin
			if (used[e]) begin
				role = $urandom_range(0, 2);
				c = rand_coef();
				if (role != 1) begin
					ac.push_back(c);
					ae.push_back(e[EXP_BITS-1:0]);
				end
				if (role != 0) begin
					if (role == 2 && $urandom_range(0, 2) == 0)
						bc.push_back(-c);
					else
						bc.push_back(rand_coef());
					be.push_back(e[EXP_BITS-1:0]);
				end
			end
		end
		// Interleave the loads, keeping the order within each store
		ia = 0;
		ib = 0;
		while (ia < ac.size() || ib < bc.size()) begin
			if ($urandom_range(0, 15) == 0)
				push_item(OP_NONE, rand_coef(), EXP_BITS'($urandom_range(0, 1023)));
			take_a = (ib >= bc.size()) || (ia < ac.size() && $urandom_range(0, 1) == 1);
			if (take_a) begin
				push_item(OP_LOAD_A, ac[ia], ae[ia]);
				ia++;
			end else begin
				push_item(OP_LOAD_B, bc[ib], be[ib]);
				ib++;
			end
		end
		push_item(OP_RUN, rand_coef(), EXP_BITS'($urandom_range(0, 1023)));
	endtask

	// Drive the term channel from the pending queue
	always @(posedge clk) begin : drive_terms
		bit fire;
		if (!arst_n) begin
			term_ch.valid <= 1'b0;
		end else begin
			fire = term_ch.valid && term_ch.ready;
			if (fire) begin
				void'(pending.pop_front());
				sent_n++;
			end
			if (term_ch.valid && !fire) begin
				// hold the offered item until its transfer
			end else if (pending.size() != 0 &&
				$urandom_range(0, 99) >= send_idle_pct(phase_of())) begin
				term_ch.valid       <= 1'b1;
				term_ch.operation   <= pending[0].op;
				term_ch.coefficient <= pending[0].coef;
				term_ch.exponent    <= pending[0].expo;
			end else begin
				term_ch.valid <= 1'b0;
			end
		end
	end

	// Apply back-pressure on the result channel
	always @(posedge clk) begin
		if (!arst_n)
			result_ch.ready <= 1'b0;
		else
			result_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct(phase_of()));
	end

	// Predict on each term transfer, check each result transfer, watch for hangs
	always @(posedge clk) begin : observe
		res_t want;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (term_ch.valid && term_ch.ready) begin
				apply_item(term_ch.operation, term_ch.coefficient, term_ch.exponent);
				moved = 1'b1;
			end
			if (result_ch.valid && result_ch.ready) begin
				moved = 1'b1;
				if (due_terms.size() == 0) begin
					errors++;
					// Fields shown as coef/exp/empty/last
					$display("%0t: unexpected result, expected none, got %0d/%0d/%b/%b",
						$time, result_ch.sum_coefficient, result_ch.sum_exponent,
						result_ch.empty_result, result_ch.last_term);
				end else begin
					want = due_terms.pop_front();
					if (result_ch.sum_coefficient !== want.sum_coefficient ||
						result_ch.sum_exponent !== want.sum_exponent ||
						result_ch.empty_result !== want.empty_result ||
						result_ch.last_term !== want.last_term) begin
						errors++;
						$display("%0t: mismatch, expected %0d/%0d/%b/%b, got %0d/%0d/%b/%b",
							$time, $signed(want.sum_coefficient), want.sum_exponent,
							want.empty_result, want.last_term,
							result_ch.sum_coefficient, result_ch.sum_exponent,
							result_ch.empty_result, result_ch.last_term);
					end
				end
			end
			quiet = moved ? 0 : quiet + 1;
			if (quiet >= WATCHDOG) begin
				$display("%0t: no transfer for %0d cycles", $time, WATCHDOG);
				$display("tb: errors");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int kind;
		logic [OP_BITS-1:0] sel;
		clk                 = 1'b0;
		arst_n              = 1'b0;
		term_ch.valid       = 1'b0;
		term_ch.operation   = OP_NONE;
		term_ch.coefficient = '0;
		term_ch.exponent    = '0;
		result_ch.ready     = 1'b0;
		errors   = 0;
		quiet    = 0;
		sent_n   = 0;
		stim_n   = 0;
		total_n  = 0;
		held_a_n = 0;
		held_b_n = 0;

		// Run on two empty stores
		push_item(OP_RUN, 16'sh0000, 10'd0);
		// Field extremes on both stores
		push_item(OP_LOAD_A, 16'sh7FFF, 10'd1023);
		push_item(OP_LOAD_A, 16'sh8000, 10'd0);
		push_item(OP_LOAD_B, 16'sh7FFF, 10'd1023);
		push_item(OP_LOAD_B, 16'sh8000, 10'd0);
		push_item(OP_RUN, 16'shFFFF, 10'd1023);
		// Every term cancels
		push_item(OP_LOAD_A, 16'sd5, 10'd10);
		push_item(OP_LOAD_B, -16'sd5, 10'd10);
		push_item(OP_RUN, 16'sh0000, 10'd0);
		// Unknown operation among loads
		push_item(OP_LOAD_A, 16'sd1, 10'd7);
		push_item(OP_NONE, 16'shFFFF, 10'd1023);
		push_item(OP_LOAD_B, 16'sd2, 10'd3);
		push_item(OP_NONE, 16'sh0000, 10'd0);
		push_item(OP_RUN, 16'sh0000, 10'd0);
		// Unsorted store A
		push_item(OP_LOAD_A, 16'sd1, 10'd2);
		push_item(OP_LOAD_A, 16'sd3, 10'd9);
		push_item(OP_LOAD_B, 16'sd4, 10'd5);
		push_item(OP_RUN, 16'sh0000, 10'd0);
		// Store B alone, then a partial cancel mixed with survivors
		push_item(OP_LOAD_B, -16'sd1, 10'd512);
		push_item(OP_RUN, 16'sh0000, 10'd0);
		push_item(OP_LOAD_A, 16'sd9, 10'd40);
		push_item(OP_LOAD_A, 16'sd6, 10'd20);
		push_item(OP_LOAD_B, -16'sd6, 10'd20);
		push_item(OP_LOAD_B, 16'sd8, 10'd1);
		push_item(OP_RUN, 16'sh0000, 10'd0);

		// Random part: mostly well-formed merges, some overfull stores and noise
		while (stim_n < ITEMS) begin
			kind = $urandom_range(0, 15);
			if (kind < 11) begin
				queue_merge_case($urandom_range(0, 10));
			end else if (kind < 13) begin
				queue_merge_case($urandom_range(20, 44));
			end else if (kind == 13) begin
				sel = $urandom_range(0, 1) ? OP_LOAD_B : OP_LOAD_A;
				repeat ($urandom_range(33, 36))
					push_item(sel, rand_coef(), EXP_BITS'($urandom_range(0, 1023)));
				push_item(OP_RUN, rand_coef(), EXP_BITS'($urandom_range(0, 1023)));
			end else begin
				repeat ($urandom_range(1, 6))
					push_item(OP_BITS'($urandom_range(0, 3)), rand_coef(),
						EXP_BITS'($urandom_range(0, 1023)));
			end
		end
		total_n = pending.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: all items transferred, all results in, then a quiet tail
		while (pending.size() != 0)
			@(posedge clk);
		// Let the monitor take in the final item transfer
		@(posedge clk);
		while (due_terms.size() != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);

		if (errors == 0 && due_terms.size() == 0) begin
			$display("tb: clean");
		end else begin
			if (due_terms.size() != 0)
				$display("%0t: %0d expected results never arrived", $time, due_terms.size());
			$display("tb: errors");
		end
		$finish;
	end

endmodule
